@@ hdl/sbc_pkg.sv @@
// sphere/box contact: shared widths, constants, payload types and helpers
// used by every module of the sphere_box_contact_unit block
`default_nettype none
package sbc_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_W     = 31;
    localparam int MAG_W     = 31;
    localparam int DMAG_W    = 32;
    localparam int SQ_W      = 62;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int Q_W       = 15;
    localparam int NUM_W     = MAG_W + NORM_FRAC + 1;
    localparam int DEPTH_W   = 32;
    localparam int AXES      = 3;
    localparam int FACES     = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [SQ_W-1:0] EPS_SQ =
        SQ_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000);
    localparam logic [Q_W-1:0] NORM_ONE_MAG = Q_W'(1 << NORM_FRAC);
    localparam logic signed [NORM_W-1:0] NORM_POS = NORM_W'(1 << NORM_FRAC);
    localparam logic signed [NORM_W-1:0] NORM_NEG = -NORM_POS;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef logic [2:0] face_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] center;
        logic [AXES-1:0][COORD_W-1:0] box_lo;
        logic [AXES-1:0][COORD_W-1:0] box_hi;
        logic [RAD_W-1:0]             radius;
    } query_t;

    typedef struct packed {
        logic                       contact;
        logic                       embedded;
        logic [AXES-1:0]            neg;
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [RAD_W-1:0]           radius;
        logic [SQ_W-1:0]            dsq;
        face_t                      face;
        logic [DMAG_W-1:0]          face_dist;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic logic [DMAG_W-1:0] mag33(input logic [DMAG_W:0] v);
        logic [DMAG_W:0] n;
        begin
            n = -v;
            return v[DMAG_W] ? n[DMAG_W-1:0] : v[DMAG_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/sbc_front.sv @@
// sphere/box contact front: clamp, squared distance, contact and face classification
// four stage pipeline feeding the job queue; depends on sbc_pkg
`default_nettype none
module sbc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire sbc_pkg::query_t query,
    input  wire sbc_pkg::fifo_status_t q_status,
    output logic               push,
    output sbc_pkg::job_t      push_job
);
    import sbc_pkg::*;

    logic adv;
    logic [3:0] v_reg;

    // stage 1
    logic signed [AXES-1:0][DMAG_W:0] d_reg, d_next;
    logic signed [FACES-1:0][DMAG_W:0] fd_reg, fd_next;
    logic [RAD_W-1:0] r1_reg;
    // stage 2
    logic [AXES-1:0][DMAG_W-1:0] dm_reg, dm_next;
    logic [FACES-1:0][DMAG_W-1:0] fm_reg, fm_next;
    logic [AXES-1:0] neg2_reg;
    logic far2_reg, far_next;
    logic [RAD_W-1:0] r2_reg;
    // stage 3
    logic [AXES-1:0][SQ_W-1:0] sq_reg, sq_next;
    logic [SQ_W-1:0] rsq_reg, rsq_next;
    logic [AXES-1:0][DMAG_W-1:0] pm_reg, pm_next;
    face_t [AXES-1:0] pi_reg, pi_next;
    logic [AXES-1:0][MAG_W-1:0] mag3_reg;
    logic [AXES-1:0] neg3_reg;
    logic far3_reg;
    logic [RAD_W-1:0] r3_reg;
    // stage 4
    job_t job_reg, job_next;

    logic signed [COORD_W:0] ce, le, he, t1, t2;
    logic [SUM_W-1:0] sum;
    logic [DMAG_W-1:0] best_d;
    face_t best_f;

    assign adv      = !(v_reg[3] && q_status.full);
    assign in_stall = !adv;
    assign push     = v_reg[3] && adv;
    assign push_job = job_reg;

    always_comb
    begin
        ce = '0; le = '0; he = '0; t1 = '0; t2 = '0;
        for (int i = 0; i < AXES; i++)
        begin
            ce = {query.center[i][COORD_W-1], query.center[i]};
            le = {query.box_lo[i][COORD_W-1], query.box_lo[i]};
            he = {query.box_hi[i][COORD_W-1], query.box_hi[i]};
            t1 = (ce < le) ? le : ce;
            t2 = (t1 > he) ? he : t1;
            d_next[i]      = ce - t2;
            fd_next[2*i]   = ce - le;
            fd_next[2*i+1] = he - ce;
        end
    end

    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            dm_next[i] = mag33(d_reg[i]);
            if (dm_next[i] >= DMAG_W'(r1_reg))
                far_next = 1'b1;
        end
        for (int f = 0; f < FACES; f++)
            fm_next[f] = mag33(fd_reg[f]);
    end

    always_comb
    begin
        rsq_next = r2_reg * r2_reg;
        for (int i = 0; i < AXES; i++)
        begin
            sq_next[i] = dm_reg[i][MAG_W-1:0] * dm_reg[i][MAG_W-1:0];
            if (fm_reg[2*i+1] < fm_reg[2*i])
            begin
                pm_next[i] = fm_reg[2*i+1];
                pi_next[i] = face_t'(2*i+1);
            end
            else
            begin
                pm_next[i] = fm_reg[2*i];
                pi_next[i] = face_t'(2*i);
            end
        end
    end

    always_comb
    begin
        sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        best_d = pm_reg[0];
        best_f = pi_reg[0];
        for (int i = 1; i < AXES; i++)
        begin
            if (pm_reg[i] < best_d)
            begin
                best_d = pm_reg[i];
                best_f = pi_reg[i];
            end
        end
        job_next.contact   = !far3_reg && (sum < SUM_W'(rsq_reg));
        job_next.embedded  = sum <= SUM_W'(EPS_SQ);
        job_next.neg       = neg3_reg;
        job_next.mag       = mag3_reg;
        job_next.radius    = r3_reg;
        job_next.dsq       = sum[SQ_W-1:0];
        job_next.face      = best_f;
        job_next.face_dist = best_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= d_next;
            fd_reg   <= fd_next;
            r1_reg   <= query.radius;
            dm_reg   <= dm_next;
            fm_reg   <= fm_next;
            far2_reg <= far_next;
            r2_reg   <= r1_reg;
            for (int i = 0; i < AXES; i++)
            begin
                neg2_reg[i] <= d_reg[i][DMAG_W];
                mag3_reg[i] <= dm_reg[i][MAG_W-1:0];
            end
            sq_reg   <= sq_next;
            rsq_reg  <= rsq_next;
            pm_reg   <= pm_next;
            pi_reg   <= pi_next;
            neg3_reg <= neg2_reg;
            far3_reg <= far2_reg;
            r3_reg   <= r2_reg;
            job_reg  <= job_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/sbc_fifo.sv @@
// sphere/box contact job queue between front and back
// small register file fifo; depends on sbc_pkg
`default_nettype none
module sbc_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sbc_pkg::job_t push_job,
    input  wire logic          pop,
    output sbc_pkg::job_t      head,
    output sbc_pkg::fifo_status_t status
);
    import sbc_pkg::*;

    job_t mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0] count_reg;
    logic do_push, do_pop;

    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

@@ hdl/sbc_back.sv @@
// sphere/box contact back: pipelined square root, normal division, result register
// one bit of root per stage, one quotient bit per stage; depends on sbc_pkg
`default_nettype none
module sbc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sbc_pkg::job_t head,
    input  wire sbc_pkg::fifo_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               contact,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [31:0]        depth
);
    import sbc_pkg::*;

    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = Q_W;

    logic adv;

    logic sq_v_reg [SQ_STEPS];
    job_t sq_job_reg [SQ_STEPS];
    logic [REM_W-1:0] sq_rem_reg [SQ_STEPS];
    logic [ROOT_W-1:0] sq_root_reg [SQ_STEPS];
    logic [REM_W-1:0] sq_rem_next [SQ_STEPS];
    logic [ROOT_W-1:0] sq_root_next [SQ_STEPS];

    logic pr_v_reg;
    job_t pr_job_reg;
    logic [ROOT_W-1:0] pr_dist_reg;
    logic [AXES-1:0][NUM_W-1:0] pr_num_reg, pr_num_next;

    logic dv_v_reg [DIV_STEPS];
    job_t dv_job_reg [DIV_STEPS];
    logic [ROOT_W-1:0] dv_dist_reg [DIV_STEPS];
    logic [AXES-1:0][NUM_W-1:0] dv_rem_reg [DIV_STEPS];
    logic [AXES-1:0][Q_W-1:0] dv_q_reg [DIV_STEPS];
    logic [AXES-1:0][NUM_W-1:0] dv_rem_next [DIV_STEPS];
    logic [AXES-1:0][Q_W-1:0] dv_q_next [DIV_STEPS];

    logic contact_next;
    logic signed [AXES-1:0][NORM_W-1:0] nrm_next;
    logic [DEPTH_W-1:0] depth_next;

    assign adv = !(out_valid && out_stall);
    assign pop = adv && !q_status.empty;

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sq
            logic [REM_W-1:0] src_rem, cur, trial;
            logic [ROOT_W-1:0] src_root;
            logic [SQ_W-1:0] src_dsq;
            if (k == 0)
            begin : g_first
                assign src_rem  = '0;
                assign src_root = '0;
                assign src_dsq  = head.dsq;
            end
            else
            begin : g_rest
                assign src_rem  = sq_rem_reg[k-1];
                assign src_root = sq_root_reg[k-1];
                assign src_dsq  = sq_job_reg[k-1].dsq;
            end
            assign cur   = {src_rem[REM_W-3:0], src_dsq[SQ_W-1-2*k -: 2]};
            assign trial = REM_W'({src_root, 2'b01});
            always_comb
            begin
                if (cur >= trial)
                begin
                    sq_rem_next[k]  = cur - trial;
                    sq_root_next[k] = {src_root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_next[k]  = cur;
                    sq_root_next[k] = {src_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [AXES-1:0][NUM_W-1:0] src_rem;
            logic [AXES-1:0][Q_W-1:0] src_q;
            logic [ROOT_W-1:0] src_dist;
            logic [NUM_W-1:0] dsh;
            if (k == 0)
            begin : g_first
                assign src_rem  = pr_num_reg;
                assign src_q    = '0;
                assign src_dist = pr_dist_reg;
            end
            else
            begin : g_rest
                assign src_rem  = dv_rem_reg[k-1];
                assign src_q    = dv_q_reg[k-1];
                assign src_dist = dv_dist_reg[k-1];
            end
            assign dsh = NUM_W'(src_dist) << (DIV_STEPS - 1 - k);
            always_comb
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    dv_rem_next[k][i] = src_rem[i];
                    dv_q_next[k][i]   = src_q[i];
                    if (src_rem[i] >= dsh)
                    begin
                        dv_rem_next[k][i] = src_rem[i] - dsh;
                        dv_q_next[k][i][DIV_STEPS-1-k] = 1'b1;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            pr_num_next[i] = {1'b0, sq_job_reg[SQ_STEPS-1].mag[i], NORM_FRAC'(0)}
                + NUM_W'(sq_root_reg[SQ_STEPS-1] >> 1);
    end

    always_comb
    begin
        job_t j;
        logic [Q_W-1:0] qs;
        logic [DEPTH_W:0] dsum;
        j = dv_job_reg[DIV_STEPS-1];
        qs = '0;
        dsum = {1'b0, j.face_dist} + (DEPTH_W+1)'(j.radius);
        contact_next = j.contact;
        nrm_next = '0;
        depth_next = '0;
        if (j.contact)
        begin
            if (j.embedded)
            begin
                nrm_next[j.face[2:1]] = j.face[0] ? NORM_POS : NORM_NEG;
                depth_next = dsum[DEPTH_W] ? DEPTH_MAX : dsum[DEPTH_W-1:0];
            end
            else
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    qs = (dv_q_reg[DIV_STEPS-1][i] > NORM_ONE_MAG)
                        ? NORM_ONE_MAG : dv_q_reg[DIV_STEPS-1][i];
                    nrm_next[i] = j.neg[i] ? -NORM_W'(qs) : NORM_W'(qs);
                end
                depth_next = DEPTH_W'(j.radius) - DEPTH_W'(dv_dist_reg[DIV_STEPS-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQ_STEPS; s++)
                sq_v_reg[s] <= 1'b0;
            for (int s = 0; s < DIV_STEPS; s++)
                dv_v_reg[s] <= 1'b0;
            pr_v_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= pop;
            for (int s = 1; s < SQ_STEPS; s++)
                sq_v_reg[s] <= sq_v_reg[s-1];
            pr_v_reg <= sq_v_reg[SQ_STEPS-1];
            dv_v_reg[0] <= pr_v_reg;
            for (int s = 1; s < DIV_STEPS; s++)
                dv_v_reg[s] <= dv_v_reg[s-1];
            out_valid <= dv_v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_job_reg[0] <= head;
            for (int s = 1; s < SQ_STEPS; s++)
                sq_job_reg[s] <= sq_job_reg[s-1];
            for (int s = 0; s < SQ_STEPS; s++)
            begin
                sq_rem_reg[s]  <= sq_rem_next[s];
                sq_root_reg[s] <= sq_root_next[s];
            end
            pr_job_reg  <= sq_job_reg[SQ_STEPS-1];
            pr_dist_reg <= sq_root_reg[SQ_STEPS-1];
            pr_num_reg  <= pr_num_next;
            dv_job_reg[0]  <= pr_job_reg;
            dv_dist_reg[0] <= pr_dist_reg;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                dv_job_reg[s]  <= dv_job_reg[s-1];
                dv_dist_reg[s] <= dv_dist_reg[s-1];
            end
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                dv_rem_reg[s] <= dv_rem_next[s];
                dv_q_reg[s]   <= dv_q_next[s];
            end
            contact  <= contact_next;
            normal_x <= nrm_next[0];
            normal_y <= nrm_next[1];
            normal_z <= nrm_next[2];
            depth    <= depth_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/sphere_box_contact_unit.sv @@
// sphere/box contact unit: top level joining front, job queue and back
// pipeline: front stages, job queue, 31 root steps, 1 prep, 15 divide steps,
// 1 result register; throughput: one item per cycle when not stalled,
// one root bit and one quotient bit per stage
// reset: asynchronous active low, clears valids and queue pointers only
`default_nettype none
module sphere_box_contact_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] center_z,
    input  wire logic [30:0]        sphere_radius,
    input  wire logic signed [31:0] box_min_x,
    input  wire logic signed [31:0] box_min_y,
    input  wire logic signed [31:0] box_min_z,
    input  wire logic signed [31:0] box_max_x,
    input  wire logic signed [31:0] box_max_y,
    input  wire logic signed [31:0] box_max_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    contact,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic signed [15:0]      normal_z,
    output logic [31:0]             depth
);
    import sbc_pkg::*;

    query_t query;
    fifo_status_t q_status;
    logic push, pop;
    job_t push_job, head;

    assign query.center = {center_z, center_y, center_x};
    assign query.box_lo = {box_min_z, box_min_y, box_min_x};
    assign query.box_hi = {box_max_z, box_max_y, box_max_x};
    assign query.radius = sphere_radius;

    sbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .query    (query),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    sbc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    sbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .contact   (contact),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .depth     (depth)
    );

endmodule
`default_nettype wire

@@ verif/sphere_box_contact_unit_tb.sv @@
// testbench for sphere_box_contact_unit: directed and random contact queries
// checked against an in-bench contact predictor; depends on the dut only
`default_nettype none
module sphere_box_contact_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam logic [63:0] EPS_SQ_V = ((64'd1 << 32) + 64'd500000) / 64'd1000000;
    localparam int NORM_ONE = 16384;

    typedef struct packed {
        logic               contact;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [31:0]        depth;
    } contact_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
    logic [30:0] sphere_radius = '0;
    logic signed [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
    logic signed [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic contact;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [31:0] depth;

    contact_word_t expected_contacts[$];
    int  errors = 0;
    int  sent = 0;
    int  received = 0;
    int  idle_pct = 31;
    int  quiet_cycles = 0;
    int  inside_hits = 0;
    int  outside_hits = 0;

    always #1 clk = ~clk;

    sphere_box_contact_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .sphere_radius(sphere_radius),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .contact(contact), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .depth(depth)
    );

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] normal_part(input logic signed [63:0] dv,
                                                       input logic [63:0] root_d);
        logic [63:0] q;
        q = ((abs64(dv) << 14) + (root_d >> 1)) / root_d;
        if (q > NORM_ONE) q = NORM_ONE;
        return dv < 0 ? -16'(q) : 16'(q);
    endfunction

    function automatic contact_word_t predict_contact(
        input logic signed [31:0] c[3], input logic signed [31:0] lo[3],
        input logic signed [31:0] hi[3], input logic [30:0] rad);
        contact_word_t w;
        logic signed [63:0] d[3], t;
        logic [63:0] r, dsq, root_d, dep, fd[6];
        logic signed [15:0] n[3];
        int best;
        w = '0;
        r = 64'(rad);
        dsq = 0;
        n[0] = 0; n[1] = 0; n[2] = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = c[i] < lo[i] ? lo[i] : c[i];
            t = t > hi[i] ? 64'(hi[i]) : t;
            d[i] = 64'(c[i]) - t;
        end
        for (int i = 0; i < 3; i++)
            if (abs64(d[i]) >= r) return w;
        for (int i = 0; i < 3; i++) dsq += abs64(d[i]) * abs64(d[i]);
        if (dsq >= r * r) return w;
        if (dsq > EPS_SQ_V)
        begin
            root_d = root_floor(dsq);
            for (int i = 0; i < 3; i++) n[i] = normal_part(d[i], root_d);
            dep = r - root_d;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                fd[2*i]   = abs64(64'(c[i]) - 64'(lo[i]));
                fd[2*i+1] = abs64(64'(hi[i]) - 64'(c[i]));
            end
            best = 0;
            for (int i = 1; i < 6; i++)
                if (fd[i] < fd[best]) best = i;
            n[best/2] = (best % 2) ? 16'(NORM_ONE) : -16'(NORM_ONE);
            dep = fd[best] > 64'hFFFFFFFF ? 64'hFFFFFFFF : fd[best];
            dep = dep + r;
            if (dep > 64'hFFFFFFFF) dep = 64'hFFFFFFFF;
        end
        w.contact = 1'b1;
        w.nx = n[0]; w.ny = n[1]; w.nz = n[2];
        w.depth = dep[31:0];
        return w;
    endfunction

    task automatic send_query(input logic signed [31:0] c[3], input logic signed [31:0] lo[3],
                              input logic signed [31:0] hi[3], input logic [30:0] rad);
        contact_word_t w;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        w = predict_contact(c, lo, hi, rad);
        if (w.contact)
        begin
            if (w.nx == NORM_ONE || w.nx == -NORM_ONE || w.ny == NORM_ONE ||
                w.ny == -NORM_ONE || w.nz == NORM_ONE || w.nz == -NORM_ONE)
                inside_hits++;
            else
                outside_hits++;
        end
        expected_contacts.insert(expected_contacts.size(), w);
        in_valid <= 1'b1;
        center_x <= c[0]; center_y <= c[1]; center_z <= c[2];
        box_min_x <= lo[0]; box_min_y <= lo[1]; box_min_z <= lo[2];
        box_max_x <= hi[0]; box_max_y <= hi[1]; box_max_z <= hi[2];
        sphere_radius <= rad;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < idle_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected word contact=%0d", $realtime, contact);
                errors++;
            end
            else
            begin
                automatic contact_word_t e = expected_contacts.pop_front();
                if (contact !== e.contact || normal_x !== e.nx || normal_y !== e.ny ||
                    normal_z !== e.nz || depth !== e.depth)
                begin
                    $display("%0t: expected %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d",
                             $realtime, e.contact, e.nx, e.ny, e.nz, e.depth,
                             contact, normal_x, normal_y, normal_z, depth);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress");
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(4))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] c[3], lo[3], hi[3];
        for (int i = 0; i < 3; i++)
        begin
            c[i] = 0; lo[i] = -32'sd65536; hi[i] = 32'sd65536;
        end
        send_query(c, lo, hi, 31'd0);
        send_query(c, lo, hi, 31'h7FFFFFFF);
        send_query(c, lo, hi, 31'd32768);
        for (int f = 0; f < 6; f++)
        begin
            c[0] = 0; c[1] = 0; c[2] = 0;
            c[f/2] = (f % 2) ? 32'sd60000 : -32'sd60000;
            send_query(c, lo, hi, 31'd65536);
        end
        c[0] = 32'sd100000; c[1] = 32'sd70000; c[2] = -32'sd90000;
        send_query(c, lo, hi, 31'd200000);
        send_query(c, lo, hi, 31'd10);
        c[0] = 32'sd65537; c[1] = 0; c[2] = 0;
        send_query(c, lo, hi, 31'd2);
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = 32'sd100; hi[i] = -32'sd100; c[i] = 0;
        end
        send_query(c, lo, hi, 31'd1000);
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = 32'sh80000000; hi[i] = 32'sh7FFFFFFF; c[i] = 32'sh7FFFFFFF;
        end
        send_query(c, lo, hi, 31'h7FFFFFFF);
        c[0] = 32'sh80000000; c[1] = 32'sh80000000; c[2] = 32'sh80000000;
        send_query(c, lo, hi, 31'd1);
        c[0] = 32'sh7FFFFFFF;
        for (int i = 0; i < 3; i++) begin lo[i] = 32'sh80000000; hi[i] = 32'sh80000000; end
        send_query(c, lo, hi, 31'h7FFFFFFF);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] c[3], lo[3], hi[3], a, b, span;
        logic [30:0] rad;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 3) idle_pct = 0;
            if (n == count / 2) idle_pct = 31;
            span = $urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 20));
            for (int i = 0; i < 3; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    lo[i] = rnd32(); hi[i] = rnd32(); c[i] = rnd32();
                end
                else
                begin
                    a = $signed($urandom_range(1 << 22)) - (1 << 21);
                    b = a + $signed($urandom_range(1 << 20));
                    lo[i] = a; hi[i] = b;
                    c[i] = a + $signed($urandom_range(1 << 21)) - (1 << 20) +
                           ($urandom_range(3) == 0 ? 0 : $signed(span >>> 12));
                    if ($urandom_range(3) == 0) c[i] = $urandom_range(1) ? a : b;
                end
            end
            case ($urandom_range(3))
                0: rad = 31'($urandom);
                1: rad = 31'($urandom_range(1 << 16));
                default: rad = 31'($urandom_range(1 << 21));
            endcase
            send_query(c, lo, hi, rad);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(650);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_contacts.size() != 0)
        begin
            $display("%0d expected words never arrived", expected_contacts.size());
            errors++;
        end
        $display("%0d queries sent, %0d words checked", sent, received);
        $display("%0d face contacts, %0d edge/corner contacts", inside_hits, outside_hits);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hdl/sbc_pkg.sv
hdl/sbc_front.sv
hdl/sbc_fifo.sv
hdl/sbc_back.sv
hdl/sphere_box_contact_unit.sv
verif/sphere_box_contact_unit_tb.sv
